>>> design/sdh_pkg.sv
// ----------------------------------------------------------------------------
// SD card SPI host package
// Shared types, phase and code constants for the SD card SPI host engine.
// ----------------------------------------------------------------------------
package sdh_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int WAKE_BYTES  = 10;
  localparam int MAX_RES     = 3;

  // Request and event codes on the input channel.
  localparam logic [2:0] F_REPLY   = 3'd0;
  localparam logic [2:0] F_INIT    = 3'd1;
  localparam logic [2:0] F_READ    = 3'd2;
  localparam logic [2:0] F_WRITE   = 3'd3;
  localparam logic [2:0] F_SYNC    = 3'd4;
  localparam logic [2:0] F_PAYLOAD = 3'd5;
  localparam logic [2:0] F_TICK    = 3'd6;

  localparam logic [1:0] K_SEND = 2'd0;
  localparam logic [1:0] K_DATA = 2'd1;
  localparam logic [1:0] K_NEED = 2'd2;
  localparam logic [1:0] K_DONE = 2'd3;

  localparam logic [2:0] S_OK        = 3'd0;
  localparam logic [2:0] S_ERROR     = 3'd1;
  localparam logic [2:0] S_NOT_READY = 3'd2;
  localparam logic [2:0] S_INIT_FAIL = 3'd3;
  localparam logic [2:0] S_BUSY      = 3'd4;

  localparam logic [4:0] PH_IDLE  = 5'd0;
  localparam logic [4:0] PH_POWER = 5'd1;
  localparam logic [4:0] PH_WAKE  = 5'd2;
  localparam logic [4:0] PH_READY = 5'd3;
  localparam logic [4:0] PH_CMDB  = 5'd4;
  localparam logic [4:0] PH_R1    = 5'd5;
  localparam logic [4:0] PH_DESEL = 5'd6;
  localparam logic [4:0] PH_OCR   = 5'd7;
  localparam logic [4:0] PH_TOKEN = 5'd8;
  localparam logic [4:0] PH_RDATA = 5'd9;
  localparam logic [4:0] PH_RCRC  = 5'd10;
  localparam logic [4:0] PH_WPAD  = 5'd11;
  localparam logic [4:0] PH_WNEED = 5'd12;
  localparam logic [4:0] PH_WDATA = 5'd13;
  localparam logic [4:0] PH_WCRC  = 5'd14;
  localparam logic [4:0] PH_WRESP = 5'd15;
  localparam logic [4:0] PH_BUSYW = 5'd16;

  localparam logic [2:0] J_NONE  = 3'd0;
  localparam logic [2:0] J_INIT  = 3'd1;
  localparam logic [2:0] J_READ  = 3'd2;
  localparam logic [2:0] J_WRITE = 3'd3;
  localparam logic [2:0] J_SYNC  = 3'd4;

  localparam logic [3:0] D_CMDFAIL  = 4'd0;
  localparam logic [3:0] D_CMD0     = 4'd1;
  localparam logic [3:0] D_CMD8     = 4'd2;
  localparam logic [3:0] D_APP      = 4'd3;
  localparam logic [3:0] D_ACMD41   = 4'd4;
  localparam logic [3:0] D_CMD58    = 4'd5;
  localparam logic [3:0] D_INITOK   = 4'd6;
  localparam logic [3:0] D_INITFAIL = 4'd7;
  localparam logic [3:0] D_ERR      = 4'd8;
  localparam logic [3:0] D_OK       = 4'd9;

  localparam logic [2:0] R_READY_TO  = 3'd0;
  localparam logic [2:0] R_RESET_RT  = 3'd1;
  localparam logic [2:0] R_OPCOND_RT = 3'd2;
  localparam logic [2:0] R_TOKEN_TO  = 3'd3;
  localparam logic [2:0] R_TRIES     = 3'd4;
  localparam logic [2:0] R_POWER_UP  = 3'd5;

  typedef struct packed {
    logic [15:0] ready_timeout_ms;
    logic [15:0] reset_retry_ms;
    logic [15:0] op_cond_retry_ms;
    logic [15:0] token_timeout_ms;
    logic [7:0]  response_tries;
    logic [7:0]  power_up_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  miso_byte;
    logic [7:0]  payload_byte;
    logic [31:0] sector;
    logic [7:0]  sector_count;
  } item_t;

  typedef struct packed {
    logic [4:0]  phase;
    logic        initialized;
    logic        block_addressed;
    logic        version_two;
    logic [5:0]  command_index;
    logic [31:0] command_argument;
    logic [9:0]  byte_counter;
    logic [15:0] millisecond_timer;
    logic [15:0] window_ms;
    logic [7:0]  tries_left;
    logic [31:0] response_word;
    logic [31:0] card_address;
    logic [7:0]  blocks_left;
    logic [2:0]  job;
    logic [3:0]  desel_then;
  } state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic       chip_select_high;
    logic       fast_clock;
    logic [2:0] status;
    logic       card_ready;
    logic       high_capacity;
    logic       last;
  } res_t;

endpackage

>>> design/sdh_step.sv
// ----------------------------------------------------------------------------
// SD card SPI host step logic
// Computes the next engine state and up to three results for one item.
// ----------------------------------------------------------------------------
module sdh_step (
  input  sdh_pkg::cfg_t                  cfg,
  input  sdh_pkg::state_t                cur,
  input  sdh_pkg::item_t                 item,
  output sdh_pkg::state_t                nxt,
  output sdh_pkg::res_t [2:0]            res,
  output logic [1:0]                     nres
);
  import sdh_pkg::*;

  function automatic void put(inout state_t s, inout res_t [2:0] r, inout logic [1:0] n,
                              input logic [1:0] k, input logic [7:0] v, input logic csh,
                              input logic [2:0] st, input logic lst);
    res_t e;
    e.kind             = k;
    e.byte_value       = v;
    e.chip_select_high = csh;
    e.fast_clock       = s.initialized;
    e.status           = st;
    e.card_ready       = s.initialized;
    e.high_capacity    = s.block_addressed;
    e.last             = lst;
    if (n != 2'd3) begin
      r[n] = e;
      n    = n + 2'd1;
    end
  endfunction

  function automatic void send_sel(inout state_t s, inout res_t [2:0] r,
                                   inout logic [1:0] n, input logic [7:0] b);
    put(s, r, n, K_SEND, b, 1'b0, S_OK, 1'b0);
  endfunction

  function automatic void deselect(inout state_t s, inout res_t [2:0] r,
                                   inout logic [1:0] n, input logic [3:0] then_code);
    s.phase      = PH_DESEL;
    s.desel_then = then_code;
    put(s, r, n, K_SEND, 8'hFF, 1'b1, S_OK, 1'b0);
  endfunction

  function automatic void finish(inout state_t s, inout res_t [2:0] r,
                                 inout logic [1:0] n, input logic [2:0] st);
    s.phase = PH_IDLE;
    s.job   = J_NONE;
    put(s, r, n, K_DONE, 8'h00, 1'b1, st, 1'b1);
  endfunction

  function automatic logic [7:0] cmd_byte(input state_t s, input logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0:    b = {2'b01, s.command_index};
      3'd1:    b = s.command_argument[31:24];
      3'd2:    b = s.command_argument[23:16];
      3'd3:    b = s.command_argument[15:8];
      3'd4:    b = s.command_argument[7:0];
      default: begin
        if (s.command_index == 6'd0) b = 8'h95;
        else if (s.command_index == 6'd8) b = 8'h87;
        else b = 8'h01;
      end
    endcase
    return b;
  endfunction

  function automatic void cmd_start(inout state_t s, inout res_t [2:0] r,
                                    inout logic [1:0] n, input logic [5:0] idx,
                                    input logic [31:0] arg);
    s.command_index    = idx;
    s.command_argument = arg;
    if (idx == 6'd0) begin
      s.byte_counter = '0;
      s.phase        = PH_CMDB;
      send_sel(s, r, n, cmd_byte(s, 3'd0));
    end else begin
      s.millisecond_timer = '0;
      s.phase             = PH_READY;
      send_sel(s, r, n, 8'hFF);
    end
  endfunction

  function automatic void next_block(inout state_t s, inout res_t [2:0] r,
                                     inout logic [1:0] n);
    if (s.blocks_left == 8'd0) deselect(s, r, n, D_OK);
    else cmd_start(s, r, n, (s.job == J_READ) ? 6'd17 : 6'd24, s.card_address);
  endfunction

  function automatic void block_done(inout state_t s, inout res_t [2:0] r,
                                     inout logic [1:0] n);
    s.card_address = s.card_address + (s.block_addressed ? 32'd1 : 32'(BLOCK_BYTES));
    s.blocks_left  = s.blocks_left - 8'd1;
    next_block(s, r, n);
  endfunction

  function automatic void start_ocr(inout state_t s, inout res_t [2:0] r,
                                    inout logic [1:0] n);
    s.byte_counter  = '0;
    s.response_word = '0;
    s.phase         = PH_OCR;
    send_sel(s, r, n, 8'hFF);
  endfunction

  function automatic void deliver(inout state_t s, inout res_t [2:0] r,
                                  inout logic [1:0] n, input logic [7:0] r1);
    s.response_word = {24'd0, r1};
    case (s.command_index)
      6'd0:  deselect(s, r, n, D_CMD0);
      6'd8: begin
        if (r1 == 8'd1) start_ocr(s, r, n);
        else begin
          s.version_two = 1'b0;
          deselect(s, r, n, D_CMD8);
        end
      end
      6'd55: deselect(s, r, n, D_APP);
      6'd41: deselect(s, r, n, D_ACMD41);
      6'd58: begin
        if (r1 == 8'd0) start_ocr(s, r, n);
        else begin
          s.block_addressed = 1'b0;
          deselect(s, r, n, D_CMD58);
        end
      end
      6'd16: deselect(s, r, n, (r1 != 8'd0) ? D_INITFAIL : D_INITOK);
      6'd17: begin
        if (r1 != 8'd0) deselect(s, r, n, D_ERR);
        else begin
          s.millisecond_timer = '0;
          s.phase             = PH_TOKEN;
          send_sel(s, r, n, 8'hFF);
        end
      end
      default: begin
        if (r1 != 8'd0) deselect(s, r, n, D_ERR);
        else begin
          s.byte_counter = '0;
          s.phase        = PH_WPAD;
          send_sel(s, r, n, 8'hFF);
        end
      end
    endcase
  endfunction

  function automatic void after_deselect(inout state_t s, inout res_t [2:0] r,
                                         inout logic [1:0] n, input cfg_t c);
    logic [7:0] r1;
    r1 = s.response_word[7:0];
    case (s.desel_then)
      D_CMDFAIL: deliver(s, r, n, 8'hFF);
      D_CMD0: begin
        if (r1 == 8'd1) cmd_start(s, r, n, 6'd8, 32'h1AA);
        else if (s.window_ms < c.reset_retry_ms) cmd_start(s, r, n, 6'd0, 32'd0);
        else begin
          // Give up: one more deselect dummy, then the failure report.
          deselect(s, r, n, D_INITFAIL);
          s.initialized = 1'b0;
          finish(s, r, n, S_INIT_FAIL);
        end
      end
      D_CMD8: begin
        s.window_ms = '0;
        cmd_start(s, r, n, 6'd55, 32'd0);
      end
      D_APP: begin
        if (r1 > 8'd1) begin
          s.command_index = 6'd41;
          deselect(s, r, n, D_ACMD41);
        end else begin
          cmd_start(s, r, n, 6'd41, s.version_two ? 32'h4000_0000 : 32'd0);
        end
      end
      D_ACMD41: begin
        if (r1 == 8'd0) begin
          if (s.version_two) cmd_start(s, r, n, 6'd58, 32'd0);
          else begin
            s.block_addressed = 1'b0;
            cmd_start(s, r, n, 6'd16, 32'(BLOCK_BYTES));
          end
        end else if (s.window_ms < c.op_cond_retry_ms) begin
          cmd_start(s, r, n, 6'd55, 32'd0);
        end else begin
          s.initialized = 1'b0;
          finish(s, r, n, S_INIT_FAIL);
        end
      end
      D_CMD58: begin
        if (s.block_addressed) begin
          s.initialized = 1'b1;
          finish(s, r, n, S_OK);
        end else begin
          cmd_start(s, r, n, 6'd16, 32'(BLOCK_BYTES));
        end
      end
      D_INITOK: begin
        s.initialized = 1'b1;
        finish(s, r, n, S_OK);
      end
      D_INITFAIL: begin
        s.initialized = 1'b0;
        finish(s, r, n, S_INIT_FAIL);
      end
      D_OK:    finish(s, r, n, S_OK);
      default: finish(s, r, n, S_ERROR);
    endcase
  endfunction

  function automatic void on_reply(inout state_t s, inout res_t [2:0] r,
                                   inout logic [1:0] n, input cfg_t c, input logic [7:0] b);
    case (s.phase)
      PH_WAKE: begin
        s.byte_counter = s.byte_counter + 10'd1;
        if (s.byte_counter < 10'(1 + WAKE_BYTES)) put(s, r, n, K_SEND, 8'hFF, 1'b1, S_OK, 1'b0);
        else begin
          s.window_ms = '0;
          cmd_start(s, r, n, 6'd0, 32'd0);
        end
      end
      PH_READY: begin
        if (b == 8'hFF) begin
          s.byte_counter = '0;
          s.phase        = PH_CMDB;
          send_sel(s, r, n, cmd_byte(s, 3'd0));
        end else if (s.millisecond_timer < c.ready_timeout_ms) begin
          send_sel(s, r, n, 8'hFF);
        end else begin
          s.response_word = 32'hFF;
          deselect(s, r, n, D_CMDFAIL);
        end
      end
      PH_CMDB: begin
        s.byte_counter = s.byte_counter + 10'd1;
        if (s.byte_counter < 10'd6) send_sel(s, r, n, cmd_byte(s, s.byte_counter[2:0]));
        else begin
          s.tries_left = (c.response_tries != 8'd0) ? c.response_tries : 8'd1;
          s.phase      = PH_R1;
          send_sel(s, r, n, 8'hFF);
        end
      end
      PH_R1: begin
        if (!b[7]) deliver(s, r, n, b);
        else begin
          s.tries_left = s.tries_left - 8'd1;
          if (s.tries_left == 8'd0) deliver(s, r, n, b);
          else send_sel(s, r, n, 8'hFF);
        end
      end
      PH_DESEL: after_deselect(s, r, n, c);
      PH_OCR: begin
        s.response_word = {s.response_word[23:0], b};
        s.byte_counter  = s.byte_counter + 10'd1;
        if (s.byte_counter < 10'd4) send_sel(s, r, n, 8'hFF);
        else if (s.command_index == 6'd8) begin
          s.version_two = (s.response_word[15:8] == 8'h01) && (s.response_word[7:0] == 8'hAA);
          deselect(s, r, n, D_CMD8);
        end else begin
          s.block_addressed = s.response_word[30];
          deselect(s, r, n, D_CMD58);
        end
      end
      PH_TOKEN: begin
        if (b == 8'hFF && s.millisecond_timer < c.token_timeout_ms) send_sel(s, r, n, 8'hFF);
        else if (b != 8'hFE) deselect(s, r, n, D_ERR);
        else begin
          s.byte_counter = '0;
          s.phase        = PH_RDATA;
          send_sel(s, r, n, 8'hFF);
        end
      end
      PH_RDATA: begin
        put(s, r, n, K_DATA, b, 1'b0, S_OK, s.byte_counter == 10'(BLOCK_BYTES - 1));
        s.byte_counter = s.byte_counter + 10'd1;
        if (s.byte_counter >= 10'(BLOCK_BYTES)) begin
          s.byte_counter = '0;
          s.phase        = PH_RCRC;
        end
        send_sel(s, r, n, 8'hFF);
      end
      PH_RCRC: begin
        s.byte_counter = s.byte_counter + 10'd1;
        if (s.byte_counter < 10'd2) send_sel(s, r, n, 8'hFF);
        else block_done(s, r, n);
      end
      PH_WPAD: begin
        if (s.byte_counter == 10'd0) begin
          s.byte_counter = 10'd1;
          send_sel(s, r, n, 8'hFE);
        end else begin
          s.byte_counter = '0;
          s.phase        = PH_WNEED;
          put(s, r, n, K_NEED, 8'h00, 1'b0, S_OK, 1'b0);
        end
      end
      PH_WDATA: begin
        s.byte_counter = s.byte_counter + 10'd1;
        if (s.byte_counter < 10'(BLOCK_BYTES)) begin
          s.phase = PH_WNEED;
          put(s, r, n, K_NEED, 8'h00, 1'b0, S_OK, 1'b0);
        end else begin
          s.byte_counter = '0;
          s.phase        = PH_WCRC;
          send_sel(s, r, n, 8'hFF);
        end
      end
      PH_WCRC: begin
        s.byte_counter = s.byte_counter + 10'd1;
        if (s.byte_counter >= 10'd2) s.phase = PH_WRESP;
        send_sel(s, r, n, 8'hFF);
      end
      PH_WRESP: begin
        if (b[4:0] != 5'h05) deselect(s, r, n, D_ERR);
        else begin
          s.millisecond_timer = '0;
          s.phase             = PH_BUSYW;
          send_sel(s, r, n, 8'hFF);
        end
      end
      PH_BUSYW: begin
        if (b == 8'hFF) begin
          if (s.job == J_WRITE) block_done(s, r, n);
          else deselect(s, r, n, D_OK);
        end else if (s.millisecond_timer < c.ready_timeout_ms) begin
          send_sel(s, r, n, 8'hFF);
        end else begin
          deselect(s, r, n, D_ERR);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void start_wake(inout state_t s, inout res_t [2:0] r,
                                     inout logic [1:0] n);
    s.byte_counter = '0;
    s.phase        = PH_WAKE;
    put(s, r, n, K_SEND, 8'hFF, 1'b1, S_OK, 1'b0);
  endfunction

  always_comb begin
    state_t           s;
    res_t [2:0]       r;
    logic [1:0]       n;
    logic             request;
    s       = cur;
    r       = '0;
    n       = 2'd0;
    request = (item.func >= F_INIT) && (item.func <= F_SYNC);
    if (request && s.phase != PH_IDLE) begin
      put(s, r, n, K_DONE, 8'h00, 1'b1, S_BUSY, 1'b1);
    end else begin
      case (item.func)
        F_REPLY: on_reply(s, r, n, cfg, item.miso_byte);
        F_INIT: begin
          s.job               = J_INIT;
          s.initialized       = 1'b0;
          s.version_two       = 1'b0;
          s.block_addressed   = 1'b0;
          s.millisecond_timer = '0;
          if (cfg.power_up_ms == 8'd0) start_wake(s, r, n);
          else s.phase = PH_POWER;
        end
        F_READ, F_WRITE: begin
          if (!s.initialized) put(s, r, n, K_DONE, 8'h00, 1'b1, S_NOT_READY, 1'b1);
          else begin
            s.job          = (item.func == F_READ) ? J_READ : J_WRITE;
            s.card_address = s.block_addressed ? item.sector : {item.sector[22:0], 9'd0};
            s.blocks_left  = item.sector_count;
            next_block(s, r, n);
          end
        end
        F_SYNC: begin
          if (!s.initialized) put(s, r, n, K_DONE, 8'h00, 1'b1, S_NOT_READY, 1'b1);
          else begin
            s.job               = J_SYNC;
            s.millisecond_timer = '0;
            s.phase             = PH_BUSYW;
            send_sel(s, r, n, 8'hFF);
          end
        end
        F_PAYLOAD: begin
          if (s.phase == PH_WNEED) begin
            s.phase = PH_WDATA;
            send_sel(s, r, n, item.payload_byte);
          end
        end
        F_TICK: begin
          if (s.millisecond_timer != 16'hFFFF) s.millisecond_timer = s.millisecond_timer + 16'd1;
          if (s.window_ms != 16'hFFFF) s.window_ms = s.window_ms + 16'd1;
          if (s.phase == PH_POWER && s.millisecond_timer >= {8'd0, cfg.power_up_ms}) begin
            start_wake(s, r, n);
          end
        end
        default: ;
      endcase
    end
    nxt  = s;
    res  = r;
    nres = n;
  end

endmodule

>>> design/sdh_out_fifo.sv
// ----------------------------------------------------------------------------
// SD card SPI host result queue
// Small queue that takes up to three results a cycle and hands out one.
// ----------------------------------------------------------------------------
module sdh_out_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  sdh_pkg::res_t [2:0]  push_data,
  input  logic [1:0]           push_count,
  input  logic                 pop,
  output sdh_pkg::res_t        head,
  output logic                 not_empty,
  output logic                 has_room
);
  import sdh_pkg::*;

  localparam int DEPTH = 8;

  res_t       mem [DEPTH];
  logic [2:0] rd_ptr;
  logic [2:0] wr_ptr;
  logic [3:0] count;

  assign head      = mem[rd_ptr];
  assign not_empty = (count != 4'd0);
  // Room for a full burst of results, whatever is popped this cycle.
  assign has_room  = (count <= 4'(DEPTH - MAX_RES));

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < push_count) mem[wr_ptr + 3'(i)] <= push_data[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + {1'b0, push_count};
      if (pop) rd_ptr <= rd_ptr + 3'd1;
      count <= count + {2'b00, push_count} - {3'b000, pop};
    end
  end

endmodule

>>> design/sd_card_spi_host_engine_top.sv
// ----------------------------------------------------------------------------
// SD card SPI host engine
// SPI-mode SD card host: init, multi-block read/write and sync, one serial
// byte exchange per input item.
//
//   Channel   Direction  Handshake                Carries
//   in        input      in_valid / in_ready      func, miso_byte, payload_byte,
//                                                 sector, sector_count
//   out       output     out_valid / out_ready    kind, byte_value, status, flags
//   cfg       input      cfg_write                cfg_index, cfg_data
//
// An accepted item is registered, stepped through the engine once the queue
// has room, and its results (up to three) enter an eight-entry result queue.
// One item per cycle is taken while the queue has room for a full burst;
// the queue drains one result per cycle, which sets the sustained rate.
// Reset clears the engine to idle and uninitialized, and loads the register
// defaults. A stall on the output backs up through the queue to in_ready.
// ----------------------------------------------------------------------------
module sd_card_spi_host_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [7:0]  miso_byte,
  input  logic [7:0]  payload_byte,
  input  logic [31:0] sector,
  input  logic [7:0]  sector_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  byte_value,
  output logic        chip_select_high,
  output logic        fast_clock,
  output logic [2:0]  status,
  output logic        card_ready,
  output logic        high_capacity,
  output logic        last,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import sdh_pkg::*;

  cfg_t       cfg;
  state_t     state;
  state_t     state_next;
  item_t      held;
  logic       held_valid;
  res_t [2:0] step_res;
  logic [1:0] step_count;
  logic       go;
  logic       room;
  res_t       head;

  assign go       = held_valid && room;
  assign in_ready = !held_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ready_timeout_ms <= 16'd500;
      cfg.reset_retry_ms   <= 16'd1000;
      cfg.op_cond_retry_ms <= 16'd1500;
      cfg.token_timeout_ms <= 16'd500;
      cfg.response_tries   <= 8'd200;
      cfg.power_up_ms      <= 8'd50;
    end else if (cfg_write) begin
      unique case (cfg_index)
        R_READY_TO:  cfg.ready_timeout_ms <= cfg_data;
        R_RESET_RT:  cfg.reset_retry_ms   <= cfg_data;
        R_OPCOND_RT: cfg.op_cond_retry_ms <= cfg_data;
        R_TOKEN_TO:  cfg.token_timeout_ms <= cfg_data;
        R_TRIES:     cfg.response_tries   <= cfg_data[7:0];
        R_POWER_UP:  cfg.power_up_ms      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held <= '{func: func, miso_byte: miso_byte, payload_byte: payload_byte,
                sector: sector, sector_count: sector_count};
    end
  end

  // The continuation code sits in the lowest bits of the state word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= {{($bits(state_t) - 4){1'b0}}, D_OK};
    end else if (go) begin
      state <= state_next;
    end
  end

  sdh_step u_step (
    .cfg  (cfg),
    .cur  (state),
    .item (held),
    .nxt  (state_next),
    .res  (step_res),
    .nres (step_count)
  );

  sdh_out_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_data  (step_res),
    .push_count (go ? step_count : 2'd0),
    .pop        (out_valid && out_ready),
    .head       (head),
    .not_empty  (out_valid),
    .has_room   (room)
  );

  assign kind             = head.kind;
  assign byte_value       = head.byte_value;
  assign chip_select_high = head.chip_select_high;
  assign fast_clock       = head.fast_clock;
  assign status           = head.status;
  assign card_ready       = head.card_ready;
  assign high_capacity    = head.high_capacity;
  assign last             = head.last;

endmodule

>>> design/sdh_checker.sv
// ----------------------------------------------------------------------------
// SD card SPI host port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module sdh_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] kind,
  input logic [7:0] byte_value,
  input logic       chip_select_high,
  input logic       fast_clock,
  input logic [2:0] status,
  input logic       card_ready,
  input logic       last
);
  import sdh_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_value))
    else $error("result dropped or changed while stalled");

  a_done_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == K_DONE |-> last && chip_select_high)
    else $error("done result without last or with chip select low");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != K_DONE |-> status == S_OK)
    else $error("status set on a non-final result");

  a_flags_agree: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> fast_clock == card_ready)
    else $error("fast clock and card ready disagree");

endmodule

bind sd_card_spi_host_engine_top sdh_checker u_sdh_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .kind             (kind),
  .byte_value       (byte_value),
  .chip_select_high (chip_select_high),
  .fast_clock       (fast_clock),
  .status           (status),
  .card_ready       (card_ready),
  .last             (last)
);

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// SD card SPI host engine testbench
// Drives request, exchange-reply, payload and tick items into the engine and
// checks every result against a cycle-free predictor of the engine. A card
// emulator chooses each reply byte from the predicted engine state, so that
// init, read, write and sync sequences run through, with random faults and
// timeouts mixed in. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sdh_pkg::*;

  localparam logic [2:0] F_UNUSED = 3'd7;

  localparam logic [5:0] CMD_GO_IDLE     = 6'd0;
  localparam logic [5:0] CMD_IF_COND     = 6'd8;
  localparam logic [5:0] CMD_BLOCKLEN    = 6'd16;
  localparam logic [5:0] CMD_READ_BLOCK  = 6'd17;
  localparam logic [5:0] CMD_WRITE_BLOCK = 6'd24;
  localparam logic [5:0] ACMD_OP_COND    = 6'd41;
  localparam logic [5:0] CMD_APP         = 6'd55;
  localparam logic [5:0] CMD_READ_OCR    = 6'd58;

  localparam logic [31:0] ARG_IF_COND = 32'h0000_01AA;
  localparam logic [31:0] ARG_HCS     = 32'h4000_0000;
  // Continuation left behind when a failed reset gives up; it is never taken.
  localparam int D_ABANDON = 107;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  func = F_UNUSED;
  logic [7:0]  miso_byte = 8'h00;
  logic [7:0]  payload_byte = 8'h00;
  logic [31:0] sector = 32'h0;
  logic [7:0]  sector_count = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  byte_value;
  logic        chip_select_high;
  logic        fast_clock;
  logic [2:0]  status;
  logic        card_ready;
  logic        high_capacity;
  logic        last;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = R_READY_TO;
  logic [15:0] cfg_data = 16'h0;

  sd_card_spi_host_engine_top dut (.*);

  always #2 clk = ~clk;

  // Engine copy: configuration and state.
  logic [15:0] cfg_ready_to, cfg_reset_win, cfg_opcond_win, cfg_token_to;
  logic [7:0]  cfg_tries, cfg_power_up;
  logic [4:0]  eng_phase;
  logic        eng_init, eng_blk, eng_v2;
  logic [5:0]  eng_cmd;
  logic [31:0] eng_arg, eng_resp, eng_addr;
  int unsigned eng_cnt;
  logic [15:0] eng_ms, eng_win;
  logic [7:0]  eng_tries, eng_blocks;
  logic [2:0]  eng_job;
  int          eng_then;

  res_t step_out[MAX_RES];
  int   step_n;

  typedef struct {
    item_t it;
    int    n;
    res_t  r[MAX_RES];
  } plan_t;

  plan_t plan_q[$];
  res_t  results_due[$];
  int    errors = 0;
  int    items_made = 0;

  function automatic void emit(logic [1:0] k, logic [7:0] v, logic cs, logic [2:0] st,
                               logic lst);
    res_t r;
    if (step_n >= MAX_RES) return;
    r.kind = k;
    r.byte_value = v;
    r.chip_select_high = cs;
    r.fast_clock = eng_init;
    r.status = st;
    r.card_ready = eng_init;
    r.high_capacity = eng_blk;
    r.last = lst;
    step_out[step_n] = r;
    step_n++;
  endfunction

  function automatic void send_sel(logic [7:0] b);
    emit(K_SEND, b, 1'b0, S_OK, 1'b0);
  endfunction

  function automatic void desel(int then_code);
    eng_phase = PH_DESEL;
    eng_then = then_code;
    emit(K_SEND, 8'hFF, 1'b1, S_OK, 1'b0);
  endfunction

  function automatic void close_job(logic [2:0] st);
    eng_phase = PH_IDLE;
    eng_job = J_NONE;
    emit(K_DONE, 8'h00, 1'b1, st, 1'b1);
  endfunction

  function automatic logic [7:0] cmd_byte(int unsigned k);
    case (k)
      0: return {2'b01, eng_cmd};
      1: return eng_arg[31:24];
      2: return eng_arg[23:16];
      3: return eng_arg[15:8];
      4: return eng_arg[7:0];
      default: begin
        if (eng_cmd == CMD_GO_IDLE) return 8'h95;
        if (eng_cmd == CMD_IF_COND) return 8'h87;
        return 8'h01;
      end
    endcase
  endfunction

  function automatic void cmd_begin(logic [5:0] idx, logic [31:0] arg);
    eng_cmd = idx;
    eng_arg = arg;
    if (idx == CMD_GO_IDLE) begin
      eng_cnt = 0;
      eng_phase = PH_CMDB;
      send_sel(cmd_byte(0));
    end else begin
      eng_ms = 16'h0;
      eng_phase = PH_READY;
      send_sel(8'hFF);
    end
  endfunction

  function automatic void next_block();
    if (eng_blocks == 8'h00) desel(D_OK);
    else cmd_begin(eng_job == J_READ ? CMD_READ_BLOCK : CMD_WRITE_BLOCK, eng_addr);
  endfunction

  function automatic void block_done();
    eng_addr = eng_addr + (eng_blk ? 32'd1 : 32'(BLOCK_BYTES));
    eng_blocks = eng_blocks - 8'd1;
    next_block();
  endfunction

  function automatic void start_ocr();
    eng_cnt = 0;
    eng_resp = 32'h0;
    eng_phase = PH_OCR;
    send_sel(8'hFF);
  endfunction

  function automatic void take_r1(logic [7:0] r1);
    eng_resp = {24'h0, r1};
    case (eng_cmd)
      CMD_GO_IDLE: desel(D_CMD0);
      CMD_IF_COND: begin
        if (r1 == 8'h01) start_ocr();
        else begin
          eng_v2 = 1'b0;
          desel(D_CMD8);
        end
      end
      CMD_APP: desel(D_APP);
      ACMD_OP_COND: desel(D_ACMD41);
      CMD_READ_OCR: begin
        if (r1 == 8'h00) start_ocr();
        else begin
          eng_blk = 1'b0;
          desel(D_CMD58);
        end
      end
      CMD_BLOCKLEN: desel(r1 != 8'h00 ? D_INITFAIL : D_INITOK);
      CMD_READ_BLOCK: begin
        if (r1 != 8'h00) desel(D_ERR);
        else begin
          eng_ms = 16'h0;
          eng_phase = PH_TOKEN;
          send_sel(8'hFF);
        end
      end
      default: begin
        if (r1 != 8'h00) desel(D_ERR);
        else begin
          eng_cnt = 0;
          eng_phase = PH_WPAD;
          send_sel(8'hFF);
        end
      end
    endcase
  endfunction

  function automatic void after_desel();
    logic [7:0] r1;
    r1 = eng_resp[7:0];
    case (eng_then)
      D_CMDFAIL: take_r1(8'hFF);
      D_CMD0: begin
        if (r1 == 8'h01) cmd_begin(CMD_IF_COND, ARG_IF_COND);
        else if (eng_win < cfg_reset_win) cmd_begin(CMD_GO_IDLE, 32'h0);
        else begin
          // The give-up path emits a deselect dummy and the final status together.
          desel(D_ABANDON);
          eng_phase = PH_IDLE;
          eng_init = 1'b0;
          close_job(S_INIT_FAIL);
        end
      end
      D_CMD8: begin
        eng_win = 16'h0;
        cmd_begin(CMD_APP, 32'h0);
      end
      D_APP: begin
        if (r1 > 8'h01) begin
          eng_cmd = ACMD_OP_COND;
          desel(D_ACMD41);
        end else cmd_begin(ACMD_OP_COND, eng_v2 ? ARG_HCS : 32'h0);
      end
      D_ACMD41: begin
        if (r1 == 8'h00) begin
          if (eng_v2) cmd_begin(CMD_READ_OCR, 32'h0);
          else begin
            eng_blk = 1'b0;
            cmd_begin(CMD_BLOCKLEN, 32'(BLOCK_BYTES));
          end
        end else if (eng_win < cfg_opcond_win) cmd_begin(CMD_APP, 32'h0);
        else begin
          eng_init = 1'b0;
          close_job(S_INIT_FAIL);
        end
      end
      D_CMD58: begin
        if (eng_blk) begin
          eng_init = 1'b1;
          close_job(S_OK);
        end else cmd_begin(CMD_BLOCKLEN, 32'(BLOCK_BYTES));
      end
      D_INITOK: begin
        eng_init = 1'b1;
        close_job(S_OK);
      end
      D_INITFAIL: begin
        eng_init = 1'b0;
        close_job(S_INIT_FAIL);
      end
      D_OK: close_job(S_OK);
      default: close_job(S_ERROR);
    endcase
  endfunction

  function automatic void start_wake();
    eng_cnt = 0;
    eng_phase = PH_WAKE;
    emit(K_SEND, 8'hFF, 1'b1, S_OK, 1'b0);
  endfunction

  function automatic void on_reply(logic [7:0] b);
    case (eng_phase)
      PH_WAKE: begin
        eng_cnt++;
        if (eng_cnt < 1 + WAKE_BYTES) emit(K_SEND, 8'hFF, 1'b1, S_OK, 1'b0);
        else begin
          eng_win = 16'h0;
          cmd_begin(CMD_GO_IDLE, 32'h0);
        end
      end
      PH_READY: begin
        if (b == 8'hFF) begin
          eng_cnt = 0;
          eng_phase = PH_CMDB;
          send_sel(cmd_byte(0));
        end else if (eng_ms < cfg_ready_to) send_sel(8'hFF);
        else begin
          eng_resp = 32'hFF;
          desel(D_CMDFAIL);
        end
      end
      PH_CMDB: begin
        eng_cnt++;
        if (eng_cnt < 6) send_sel(cmd_byte(eng_cnt));
        else begin
          eng_tries = (cfg_tries != 8'h00) ? cfg_tries : 8'd1;
          eng_phase = PH_R1;
          send_sel(8'hFF);
        end
      end
      PH_R1: begin
        if (!b[7]) take_r1(b);
        else begin
          eng_tries = eng_tries - 8'd1;
          if (eng_tries == 8'h00) take_r1(b);
          else send_sel(8'hFF);
        end
      end
      PH_DESEL: after_desel();
      PH_OCR: begin
        eng_resp = {eng_resp[23:0], b};
        eng_cnt++;
        if (eng_cnt < 4) send_sel(8'hFF);
        else if (eng_cmd == CMD_IF_COND) begin
          eng_v2 = (eng_resp[15:0] == 16'h01AA);
          desel(D_CMD8);
        end else begin
          eng_blk = eng_resp[30];
          desel(D_CMD58);
        end
      end
      PH_TOKEN: begin
        if (b == 8'hFF && eng_ms < cfg_token_to) send_sel(8'hFF);
        else if (b != 8'hFE) desel(D_ERR);
        else begin
          eng_cnt = 0;
          eng_phase = PH_RDATA;
          send_sel(8'hFF);
        end
      end
      PH_RDATA: begin
        emit(K_DATA, b, 1'b0, S_OK, eng_cnt == BLOCK_BYTES - 1);
        eng_cnt++;
        if (eng_cnt >= BLOCK_BYTES) begin
          eng_cnt = 0;
          eng_phase = PH_RCRC;
        end
        send_sel(8'hFF);
      end
      PH_RCRC: begin
        eng_cnt++;
        if (eng_cnt < 2) send_sel(8'hFF);
        else block_done();
      end
      PH_WPAD: begin
        if (eng_cnt == 0) begin
          eng_cnt = 1;
          send_sel(8'hFE);
        end else begin
          eng_cnt = 0;
          eng_phase = PH_WNEED;
          emit(K_NEED, 8'h00, 1'b0, S_OK, 1'b0);
        end
      end
      PH_WDATA: begin
        eng_cnt++;
        if (eng_cnt < BLOCK_BYTES) begin
          eng_phase = PH_WNEED;
          emit(K_NEED, 8'h00, 1'b0, S_OK, 1'b0);
        end else begin
          eng_cnt = 0;
          eng_phase = PH_WCRC;
          send_sel(8'hFF);
        end
      end
      PH_WCRC: begin
        eng_cnt++;
        if (eng_cnt >= 2) eng_phase = PH_WRESP;
        send_sel(8'hFF);
      end
      PH_WRESP: begin
        if (b[4:0] != 5'h05) desel(D_ERR);
        else begin
          eng_ms = 16'h0;
          eng_phase = PH_BUSYW;
          send_sel(8'hFF);
        end
      end
      PH_BUSYW: begin
        if (b == 8'hFF) begin
          if (eng_job == J_WRITE) block_done();
          else desel(D_OK);
        end else if (eng_ms < cfg_ready_to) send_sel(8'hFF);
        else desel(D_ERR);
      end
      default: ;
    endcase
  endfunction

  function automatic void engine_reset();
    cfg_ready_to = 16'd500;
    cfg_reset_win = 16'd1000;
    cfg_opcond_win = 16'd1500;
    cfg_token_to = 16'd500;
    cfg_tries = 8'd200;
    cfg_power_up = 8'd50;
    eng_phase = PH_IDLE;
    eng_init = 1'b0;
    eng_blk = 1'b0;
    eng_v2 = 1'b0;
    eng_cmd = 6'h0;
    eng_arg = 32'h0;
    eng_cnt = 0;
    eng_ms = 16'h0;
    eng_win = 16'h0;
    eng_tries = 8'h0;
    eng_resp = 32'h0;
    eng_addr = 32'h0;
    eng_blocks = 8'h0;
    eng_job = J_NONE;
    eng_then = D_OK;
  endfunction

  function automatic void engine_config(logic [2:0] idx, logic [15:0] val);
    case (idx)
      R_READY_TO:  cfg_ready_to = val;
      R_RESET_RT:  cfg_reset_win = val;
      R_OPCOND_RT: cfg_opcond_win = val;
      R_TOKEN_TO:  cfg_token_to = val;
      R_TRIES:     cfg_tries = val[7:0];
      R_POWER_UP:  cfg_power_up = val[7:0];
      default: ;
    endcase
  endfunction

  function automatic void engine_step(item_t it);
    step_n = 0;
    if (it.func >= F_INIT && it.func <= F_SYNC && eng_phase != PH_IDLE) begin
      emit(K_DONE, 8'h00, 1'b1, S_BUSY, 1'b1);
      return;
    end
    case (it.func)
      F_REPLY: on_reply(it.miso_byte);
      F_INIT: begin
        eng_job = J_INIT;
        eng_init = 1'b0;
        eng_v2 = 1'b0;
        eng_blk = 1'b0;
        eng_ms = 16'h0;
        if (cfg_power_up == 8'h00) start_wake();
        else eng_phase = PH_POWER;
      end
      F_READ, F_WRITE: begin
        if (!eng_init) emit(K_DONE, 8'h00, 1'b1, S_NOT_READY, 1'b1);
        else begin
          eng_job = (it.func == F_READ) ? J_READ : J_WRITE;
          eng_addr = eng_blk ? it.sector : {it.sector[22:0], 9'h000};
          eng_blocks = it.sector_count;
          next_block();
        end
      end
      F_SYNC: begin
        if (!eng_init) emit(K_DONE, 8'h00, 1'b1, S_NOT_READY, 1'b1);
        else begin
          eng_job = J_SYNC;
          eng_ms = 16'h0;
          eng_phase = PH_BUSYW;
          send_sel(8'hFF);
        end
      end
      F_PAYLOAD: begin
        if (eng_phase == PH_WNEED) begin
          eng_phase = PH_WDATA;
          send_sel(it.payload_byte);
        end
      end
      F_TICK: begin
        if (eng_ms != 16'hFFFF) eng_ms++;
        if (eng_win != 16'hFFFF) eng_win++;
        if (eng_phase == PH_POWER && eng_ms >= cfg_power_up) start_wake();
      end
      default: ;
    endcase
  endfunction

  // Predicts the item and queues it with its results for the driver.
  function automatic void queue_item(logic [2:0] f, logic [7:0] m, logic [7:0] p,
                                     logic [31:0] s, logic [7:0] c);
    plan_t pl;
    pl.it.func = f;
    pl.it.miso_byte = m;
    pl.it.payload_byte = p;
    pl.it.sector = s;
    pl.it.sector_count = c;
    engine_step(pl.it);
    pl.n = step_n;
    for (int i = 0; i < MAX_RES; i++) pl.r[i] = step_out[i];
    plan_q.push_back(pl);
    items_made++;
  endfunction

  // Card emulator: the byte the card clocks back, given what the engine is doing.
  function automatic logic [7:0] card_byte(int flaky);
    int roll;
    roll = $urandom_range(0, 99);
    case (eng_phase)
      PH_READY: return (roll < flaky) ? 8'($urandom_range(0, 254)) : 8'hFF;
      PH_R1: begin
        if (roll < flaky / 2) return 8'hFF;
        if (roll < flaky) return 8'($urandom);
        case (eng_cmd)
          CMD_GO_IDLE, CMD_APP: return 8'h01;
          CMD_IF_COND: return ($urandom_range(0, 3) == 0) ? 8'h05 : 8'h01;
          ACMD_OP_COND: return ($urandom_range(0, 2) == 0) ? 8'h01 : 8'h00;
          default: return 8'h00;
        endcase
      end
      PH_OCR: begin
        if (eng_cmd == CMD_IF_COND && roll >= flaky) begin
          case (eng_cnt)
            2: return 8'h01;
            3: return 8'hAA;
            default: return 8'h00;
          endcase
        end
        return 8'($urandom);
      end
      PH_TOKEN: begin
        if (roll < 30) return 8'hFF;
        if (roll < 30 + flaky / 2) return 8'($urandom);
        return 8'hFE;
      end
      PH_WRESP: return (roll < flaky / 2) ? 8'($urandom) : {3'($urandom), 5'h05};
      PH_BUSYW: return (roll < 40) ? 8'($urandom) : 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Feeds the engine until the job in progress has closed, with noise mixed in.
  function automatic void run_job(int flaky);
    int roll;
    while (eng_phase != PH_IDLE) begin
      roll = $urandom_range(0, 99);
      if (roll < 6 || eng_phase == PH_POWER)
        queue_item(F_TICK, 8'($urandom), 8'($urandom), $urandom, 8'($urandom));
      else if (roll < 8) begin
        case ($urandom_range(0, 2))
          0: queue_item(F_UNUSED, 8'($urandom), 8'($urandom), $urandom, 8'($urandom));
          1: queue_item(3'($urandom_range(F_INIT, F_SYNC)), 8'($urandom), 8'($urandom),
                        $urandom, 8'($urandom));
          default: begin
            if (eng_phase == PH_WNEED)
              queue_item(F_REPLY, 8'($urandom), 8'($urandom), $urandom, 8'($urandom));
            else queue_item(F_PAYLOAD, 8'($urandom), 8'($urandom), $urandom, 8'($urandom));
          end
        endcase
      end else if (eng_phase == PH_WNEED)
        queue_item(F_PAYLOAD, 8'($urandom), 8'($urandom), $urandom, 8'($urandom));
      else queue_item(F_REPLY, card_byte(flaky), 8'($urandom), $urandom, 8'($urandom));
    end
  endfunction

  function automatic void request(logic [2:0] f, logic [31:0] s, logic [7:0] c, int flaky);
    queue_item(f, 8'($urandom), 8'($urandom), s, c);
    run_job(flaky);
  endfunction

  function automatic void random_jobs(int flaky, int target);
    int start, roll;
    start = items_made;
    while (items_made - start < target) begin
      roll = $urandom_range(0, 99);
      if (!eng_init && roll < 10)
        request(3'($urandom_range(F_READ, F_SYNC)), $urandom, 8'($urandom), flaky);
      else if (!eng_init || roll < 15) request(F_INIT, $urandom, 8'($urandom), flaky);
      else if (roll < 35) request(F_SYNC, $urandom, 8'($urandom), flaky);
      else
        request(roll < 70 ? F_READ : F_WRITE, $urandom,
                ($urandom_range(0, 3) == 0) ? 8'd0 : 8'd1, flaky);
    end
  endfunction

  task automatic drain();
    while (plan_q.size() != 0 || results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    engine_config(idx, val);
  endtask

  task automatic set_all(logic [15:0] rdy, logic [15:0] rst_win, logic [15:0] op_win,
                         logic [15:0] tok, logic [7:0] tries, logic [7:0] pwr);
    set_reg(R_READY_TO, rdy);
    set_reg(R_RESET_RT, rst_win);
    set_reg(R_OPCOND_RT, op_win);
    set_reg(R_TOKEN_TO, tok);
    set_reg(R_TRIES, {8'h00, tries});
    set_reg(R_POWER_UP, {8'h00, pwr});
  endtask

  // Sender: bursts of random length separated by random gaps.
  logic took = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || took) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 48);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (plan_q.size() > 0) begin
        in_valid <= 1'b1;
        func <= plan_q[0].it.func;
        miso_byte <= plan_q[0].it.miso_byte;
        payload_byte <= plan_q[0].it.payload_byte;
        sector <= plan_q[0].it.sector;
        sector_count <= plan_q[0].it.sector_count;
        burst_left--;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall mode changes every so often, mode zero never stalls.
  int stall_mode = 0;
  int stall_span = 0;

  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_span = $urandom_range(20, 200);
      stall_mode = $urandom_range(0, 3);
    end
    stall_span--;
    out_ready <= (stall_mode == 0) ? 1'b1 : ($urandom_range(0, stall_mode) == 0);
  end

  always @(posedge clk) begin
    plan_t pl;
    res_t  got, want;
    if (rst) begin
      took <= 1'b0;
    end else begin
      took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        pl = plan_q.pop_front();
        for (int i = 0; i < pl.n; i++) results_due.push_back(pl.r[i]);
      end
      if (out_valid && out_ready) begin
        got = '{kind, byte_value, chip_select_high, fast_clock, status, card_ready,
                high_capacity, last};
        if (results_due.size() == 0) begin
          $error("result transfer with nothing expected: kind %0d byte %02h", kind,
                 byte_value);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (got.kind != want.kind) begin
            $error("kind expected %0d actual %0d", want.kind, got.kind);
            errors++;
          end
          if (got.byte_value != want.byte_value) begin
            $error("byte_value expected %02h actual %02h", want.byte_value, got.byte_value);
            errors++;
          end
          if (got.chip_select_high != want.chip_select_high) begin
            $error("chip_select_high expected %0d actual %0d", want.chip_select_high,
                   got.chip_select_high);
            errors++;
          end
          if (got.fast_clock != want.fast_clock) begin
            $error("fast_clock expected %0d actual %0d", want.fast_clock, got.fast_clock);
            errors++;
          end
          if (got.status != want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            errors++;
          end
          if (got.card_ready != want.card_ready) begin
            $error("card_ready expected %0d actual %0d", want.card_ready, got.card_ready);
            errors++;
          end
          if (got.high_capacity != want.high_capacity) begin
            $error("high_capacity expected %0d actual %0d", want.high_capacity,
                   got.high_capacity);
            errors++;
          end
          if (got.last != want.last) begin
            $error("last expected %0d actual %0d", want.last, got.last);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    engine_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Short timeouts, zero response tries, short power-up delay.
    set_all(16'd3, 16'd6, 16'd10, 16'd3, 8'd0, 8'd2);
    queue_item(F_TICK, 8'h00, 8'h00, 32'h0, 8'h01);
    queue_item(F_UNUSED, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
    queue_item(F_REPLY, 8'hFF, 8'h00, 32'h0, 8'h01);
    queue_item(F_PAYLOAD, 8'h00, 8'hFF, 32'h0, 8'h01);
    queue_item(F_READ, 8'h00, 8'h00, 32'hFFFF_FFFF, 8'hFF);
    queue_item(F_WRITE, 8'h00, 8'h00, 32'h0, 8'h80);
    queue_item(F_SYNC, 8'h00, 8'h00, 32'h0, 8'h01);
    request(F_INIT, 32'h0, 8'h01, 0);
    request(F_READ, 32'h1234_5678, 8'd0, 0);
    request(F_READ, 32'hFFFF_FFFF, 8'd1, 0);
    request(F_WRITE, 32'h0080_0001, 8'd1, 0);
    request(F_SYNC, 32'h0, 8'd1, 0);
    // The test holds off here until every item is sent and every expected result has been seen.
    drain();

    random_jobs(25, 150);
    drain();

    set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255);
    random_jobs(10, 60);
    drain();

    set_all(16'd1, 16'd1, 16'd1, 16'd1, 8'd1, 8'd0);
    random_jobs(35, 160);
    drain();

    repeat (40) @(posedge clk);
    if (errors == 0 && results_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
